/* sv/depth_hazard_pixel_classifier_top_defines.svh */
// Assertion macros shared by the depth hazard pixel classifier RTL.
`ifndef DEPTH_HAZARD_PIXEL_CLASSIFIER_TOP_DEFINES_SVH
`define DEPTH_HAZARD_PIXEL_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DHPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DHPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dhpc_pkg.sv */
// Types and constants shared by the depth hazard pixel classifier.
package dhpc_pkg;

    localparam int MAX_COLS = 2048;
    localparam int MAX_ROWS = 2048;

    localparam int ROW_W   = 11;
    localparam int COL_W   = 11;
    localparam int DEPTH_W = 16;
    localparam int RGB_W   = 8;
    localparam int CLASS_W = 2;
    localparam int WIN_W   = 12;
    localparam int SCALE_W = 16;
    localparam int COUNT_W = 23;
    localparam int CFG_W   = 23;
    localparam int IDX_W   = 3;
    localparam int FRAC_W  = 14;
    localparam int PROD_W  = DEPTH_W + SCALE_W;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_MM = 16'd250;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COL_W-1:0]   LEFT_RESET   = '1;
    localparam logic [COL_W-1:0]   RIGHT_RESET  = '0;
    localparam logic [RGB_W-1:0]   CHANNEL_FULL = '1;

    localparam logic [WIN_W-1:0]   FIRST_COL_RESET = 12'd0;
    localparam logic [WIN_W-1:0]   END_COL_RESET   = 12'd2048;
    localparam logic [WIN_W-1:0]   FIRST_ROW_RESET = 12'd0;
    localparam logic [WIN_W-1:0]   END_ROW_RESET   = 12'd2048;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 16'd16384;
    localparam logic [COUNT_W-1:0] LIMIT_RESET     = 23'd1;

    typedef enum logic [IDX_W-1:0] {
        REG_FIRST_COL    = 3'd0,
        REG_END_COL      = 3'd1,
        REG_FIRST_ROW    = 3'd2,
        REG_END_ROW      = 3'd3,
        REG_NEAR_SCALE   = 3'd4,
        REG_FAR_SCALE    = 3'd5,
        REG_HAZARD_LIMIT = 3'd6
    } cfg_reg_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_SKIPPED = 2'd0,
        CLASS_CLEAR   = 2'd1,
        CLASS_CLOSE   = 2'd2,
        CLASS_FAR     = 2'd3
    } pixel_class_t;

    typedef struct packed {
        logic examined;
        logic too_close;
        logic too_far;
    } hazard_flags_t;

endpackage

/* sv/depth_hazard_pixel_classifier_top.sv */
// Top level of the depth hazard pixel classifier.
// One pixel per clock in while pix_stall is low, one result per pixel out, in order.
// Three register stages (input, depth products, result) lie between request acceptance
// and result valid; each stage loads whenever it is empty or its successor loads, so
// bubbles are squeezed out and a new request is taken while a finished result waits.
// The two 16x16 calibration products and the window check sit between the input and
// product registers. Hazard count and column extremes update as a result is loaded
// and are cleared after a last-pixel result. Configuration is to be written through
// cfg_we/cfg_index/cfg_data while idle; the block itself does not enforce this.
`include "depth_hazard_pixel_classifier_top_defines.svh"

module depth_hazard_pixel_classifier_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dhpc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [dhpc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  logic [dhpc_pkg::ROW_W-1:0]       row,
    input  logic [dhpc_pkg::COL_W-1:0]       col,
    input  logic [dhpc_pkg::DEPTH_W-1:0]     depth_mm,
    input  logic                             depth_valid,
    input  logic [dhpc_pkg::DEPTH_W-1:0]     calib_mm,
    input  logic                             calib_valid,
    input  logic [dhpc_pkg::RGB_W-1:0]       red_in,
    input  logic [dhpc_pkg::RGB_W-1:0]       green_in,
    input  logic [dhpc_pkg::RGB_W-1:0]       blue_in,
    input  logic                             last_pixel,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [dhpc_pkg::RGB_W-1:0]       red_out,
    output logic [dhpc_pkg::RGB_W-1:0]       green_out,
    output logic [dhpc_pkg::RGB_W-1:0]       blue_out,
    output logic [dhpc_pkg::CLASS_W-1:0]     pixel_class,
    output logic [dhpc_pkg::COUNT_W-1:0]     hazard_total,
    output logic [dhpc_pkg::COL_W-1:0]       leftmost_col,
    output logic [dhpc_pkg::COL_W-1:0]       rightmost_col,
    output logic                             hazard_area,
    output logic                             frame_end
);
    import dhpc_pkg::*;

    // configuration
    logic [WIN_W-1:0]   first_col_reg, end_col_reg, first_row_reg, end_row_reg;
    logic [SCALE_W-1:0] near_scale_reg, far_scale_reg;
    logic [COUNT_W-1:0] hazard_limit_reg;

    // pipeline control
    logic a_en, b_en, out_en;
    logic a_valid_reg, b_valid_reg, res_valid_reg;

    // input stage
    logic [ROW_W-1:0]   a_row_reg;
    logic [COL_W-1:0]   a_col_reg;
    logic [DEPTH_W-1:0] a_depth_reg, a_calib_reg;
    logic               a_depth_ok_reg, a_calib_ok_reg, a_last_reg;
    logic [RGB_W-1:0]   a_red_reg, a_green_reg, a_blue_reg;

    // product stage
    logic               in_window, examined;
    logic               b_examined_reg, b_last_reg;
    logic [DEPTH_W-1:0] b_depth_reg;
    logic [PROD_W-1:0]  b_near_reg, b_far_reg;
    logic [COL_W-1:0]   b_col_reg;
    logic [RGB_W-1:0]   b_red_reg, b_green_reg, b_blue_reg;

    // result stage
    hazard_flags_t      flags;
    logic [PROD_W-1:0]  meas;
    logic [RGB_W-1:0]   red_c, green_c, blue_c;
    pixel_class_t       class_c;
    logic               hazard;
    logic [1:0]         inc;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] count_upd, count_reg, count_next;
    logic [COL_W-1:0]   left_upd, left_reg, left_next;
    logic [COL_W-1:0]   right_upd, right_reg, right_next;
    logic               area_c;

    logic [RGB_W-1:0]   red_reg, green_reg, blue_reg;
    logic [CLASS_W-1:0] class_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COL_W-1:0]   leftmost_reg, rightmost_reg;
    logic               area_reg, frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_col_reg    <= FIRST_COL_RESET;
            end_col_reg      <= END_COL_RESET;
            first_row_reg    <= FIRST_ROW_RESET;
            end_row_reg      <= END_ROW_RESET;
            near_scale_reg   <= SCALE_RESET;
            far_scale_reg    <= SCALE_RESET;
            hazard_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FIRST_COL:    first_col_reg    <= cfg_data[WIN_W-1:0];
                REG_END_COL:      end_col_reg      <= cfg_data[WIN_W-1:0];
                REG_FIRST_ROW:    first_row_reg    <= cfg_data[WIN_W-1:0];
                REG_END_ROW:      end_row_reg      <= cfg_data[WIN_W-1:0];
                REG_NEAR_SCALE:   near_scale_reg   <= cfg_data[SCALE_W-1:0];
                REG_FAR_SCALE:    far_scale_reg    <= cfg_data[SCALE_W-1:0];
                REG_HAZARD_LIMIT: hazard_limit_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // a stage loads when empty or when the one after it loads
    assign out_en    = !res_valid_reg || !res_stall;
    assign b_en      = !b_valid_reg || out_en;
    assign a_en      = !a_valid_reg || b_en;
    assign pix_stall = !a_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
                a_valid_reg <= pix_valid;
            if (b_en)
                b_valid_reg <= a_valid_reg;
            if (out_en)
                res_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && pix_valid)
        begin
            a_row_reg      <= row;
            a_col_reg      <= col;
            a_depth_reg    <= depth_mm;
            a_depth_ok_reg <= depth_valid;
            a_calib_reg    <= calib_mm;
            a_calib_ok_reg <= calib_valid;
            a_red_reg      <= red_in;
            a_green_reg    <= green_in;
            a_blue_reg     <= blue_in;
            a_last_reg     <= last_pixel;
        end
    end

    assign in_window = ({1'b0, a_row_reg} >= first_row_reg) &&
                       ({1'b0, a_row_reg} < end_row_reg) &&
                       (32'(a_row_reg) < MAX_ROWS) &&
                       ({1'b0, a_col_reg} >= first_col_reg) &&
                       ({1'b0, a_col_reg} < end_col_reg) &&
                       (32'(a_col_reg) < MAX_COLS);
    assign examined  = in_window && a_depth_ok_reg && a_calib_ok_reg &&
                       (a_depth_reg > MIN_DEPTH_MM);

    always_ff @(posedge clk)
    begin
        if (b_en && a_valid_reg)
        begin
            b_examined_reg <= examined;
            b_depth_reg    <= a_depth_reg;
            b_near_reg     <= PROD_W'(a_calib_reg) * PROD_W'(near_scale_reg);
            b_far_reg      <= PROD_W'(a_calib_reg) * PROD_W'(far_scale_reg);
            b_col_reg      <= a_col_reg;
            b_red_reg      <= a_red_reg;
            b_green_reg    <= a_green_reg;
            b_blue_reg     <= a_blue_reg;
            b_last_reg     <= a_last_reg;
        end
    end

    // depth in Q.14 against the scaled calibration
    assign meas            = {{(PROD_W-DEPTH_W-FRAC_W){1'b0}}, b_depth_reg, {FRAC_W{1'b0}}};
    assign flags.examined  = b_examined_reg;
    assign flags.too_close = b_examined_reg && (meas < b_near_reg);
    assign flags.too_far   = b_examined_reg && (meas > b_far_reg);

    dhpc_recolour u_recolour (
        .flags       (flags),
        .red_in      (b_red_reg),
        .green_in    (b_green_reg),
        .blue_in     (b_blue_reg),
        .red_out     (red_c),
        .green_out   (green_c),
        .blue_out    (blue_c),
        .pixel_class (class_c)
    );

    // a pixel that is both too close and too far counts twice
    assign hazard    = flags.too_close || flags.too_far;
    assign inc       = 2'(flags.too_close) + 2'(flags.too_far);
    assign sum       = {1'b0, count_reg} + (COUNT_W+1)'(inc);
    assign count_upd = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
    assign left_upd  = (hazard && (b_col_reg < left_reg)) ? b_col_reg : left_reg;
    assign right_upd = (hazard && (b_col_reg > right_reg)) ? b_col_reg : right_reg;
    assign area_c    = b_last_reg && (count_upd >= hazard_limit_reg);

    always_comb
    begin
        count_next = count_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (out_en && b_valid_reg)
        begin
            if (b_last_reg)
            begin
                count_next = '0;
                left_next  = LEFT_RESET;
                right_next = RIGHT_RESET;
            end
            else
            begin
                count_next = count_upd;
                left_next  = left_upd;
                right_next = right_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            left_reg  <= LEFT_RESET;
            right_reg <= RIGHT_RESET;
        end
        else
        begin
            count_reg <= count_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && b_valid_reg)
        begin
            red_reg       <= red_c;
            green_reg     <= green_c;
            blue_reg      <= blue_c;
            class_reg     <= class_c;
            total_reg     <= count_upd;
            leftmost_reg  <= left_upd;
            rightmost_reg <= right_upd;
            area_reg      <= area_c;
            frame_end_reg <= b_last_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign red_out       = red_reg;
    assign green_out     = green_reg;
    assign blue_out      = blue_reg;
    assign pixel_class   = class_reg;
    assign hazard_total  = total_reg;
    assign leftmost_col  = leftmost_reg;
    assign rightmost_col = rightmost_reg;
    assign hazard_area   = area_reg;
    assign frame_end     = frame_end_reg;

    `DHPC_ASSERT_NEXT(a_frame_clears, out_en && b_valid_reg && b_last_reg, count_reg == '0 && left_reg == LEFT_RESET && right_reg == RIGHT_RESET, "frame state not cleared after last pixel")
    `DHPC_ASSERT_NOW(a_area_only_at_end, res_valid && !frame_end, !hazard_area, "hazard area flagged before frame end")
    `DHPC_ASSERT_NOW(a_clear_is_green, res_valid && pixel_class == CLASS_CLEAR, green_out == CHANNEL_FULL, "clear pixel not full green")
    `DHPC_ASSERT_NOW(a_extremes_ordered, res_valid && hazard_total != '0, leftmost_col <= rightmost_col, "hazard columns out of order")
    `DHPC_ASSERT_NOW(a_full_stalls, res_valid && res_stall && b_valid_reg && a_valid_reg, pix_stall, "request taken into a full pipeline")

endmodule

/* sv/dhpc_recolour.sv */
// Pixel classification code and recolouring from the hazard flags.
module dhpc_recolour (
    input  dhpc_pkg::hazard_flags_t       flags,
    input  logic [dhpc_pkg::RGB_W-1:0]    red_in,
    input  logic [dhpc_pkg::RGB_W-1:0]    green_in,
    input  logic [dhpc_pkg::RGB_W-1:0]    blue_in,
    output logic [dhpc_pkg::RGB_W-1:0]    red_out,
    output logic [dhpc_pkg::RGB_W-1:0]    green_out,
    output logic [dhpc_pkg::RGB_W-1:0]    blue_out,
    output dhpc_pkg::pixel_class_t        pixel_class
);
    import dhpc_pkg::*;

    // floor(v*10/11): 2979/2^15 overshoots 1/11 by too little to cross an integer for v*10 <= 2550
    function automatic logic [RGB_W-1:0] div_1p1(input logic [RGB_W-1:0] v);
        logic [11:0] ten;
        logic [23:0] prod;
        ten  = {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
        prod = 24'(ten) * 24'd2979;
        return prod[22:15];
    endfunction

    // floor(v*2/3): 683/2^11 for v*2 <= 510
    function automatic logic [RGB_W-1:0] div_1p5(input logic [RGB_W-1:0] v);
        logic [8:0]  two;
        logic [18:0] prod;
        two  = {v, 1'b0};
        prod = 19'(two) * 19'd683;
        return prod[18:11];
    endfunction

    always_comb
    begin
        red_out     = red_in;
        green_out   = green_in;
        blue_out    = blue_in;
        pixel_class = CLASS_SKIPPED;
        if (flags.examined)
        begin
            red_out     = div_1p1(red_in);
            green_out   = CHANNEL_FULL;
            blue_out    = div_1p1(blue_in);
            pixel_class = CLASS_CLEAR;
            if (flags.too_close)
            begin
                red_out     = CHANNEL_FULL;
                green_out   = green_in;
                blue_out    = div_1p5(blue_out);
                pixel_class = CLASS_CLOSE;
            end
            // far wins the class when both fire, and works on the colours so far
            if (flags.too_far)
            begin
                red_out     = div_1p5(red_out);
                green_out   = green_in;
                blue_out    = CHANNEL_FULL;
                pixel_class = CLASS_FAR;
            end
        end
    end

endmodule
